[design/dqci_pkg.sv]
// ---------------------------------------------------------------------------
// dqci_pkg
// Shared widths, codes and slot arithmetic for the clamped-index deque.
// ---------------------------------------------------------------------------
package dqci_pkg;

   // Storage geometry
   localparam int DEPTH  = 16;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths
   localparam int DATA_W = 32;
   localparam int MODE_W = 3;
   localparam int POS_W  = 16;
   localparam int STAT_W = 2;

   typedef logic        [MODE_W-1:0] mode_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [POS_W-1:0]  pos_type;
   typedef logic        [CNT_W-1:0]  count_type;
   typedef logic        [STAT_W-1:0] status_type;
   typedef logic        [SLOT_W-1:0] slot_type;

   // Operation codes
   localparam mode_type MODE_PUSH_FRONT = 3'd0;
   localparam mode_type MODE_PUSH_BACK  = 3'd1;
   localparam mode_type MODE_POP_FRONT  = 3'd2;
   localparam mode_type MODE_POP_BACK   = 3'd3;
   localparam mode_type MODE_READ_IDX   = 3'd4;
   localparam mode_type MODE_WRITE_IDX  = 3'd5;

   // Status codes
   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_EMPTY = 2'd1;
   localparam status_type STAT_FULL  = 2'd2;

   // Ring slot that lies off entries after base, wrapped at DEPTH
   function automatic slot_type slot_add(input slot_type base, input slot_type off);
      logic [SLOT_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (SLOT_W + 1)'(DEPTH)) begin
         sum = sum - (SLOT_W + 1)'(DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   // Ring slot just before base, wrapped at DEPTH
   function automatic slot_type slot_dec(input slot_type base);
      slot_type prev;
      if (base == '0) begin
         prev = SLOT_W'(DEPTH - 1);
      end else begin
         prev = base - 1'b1;
      end
      return prev;
   endfunction

endpackage

[design/dqci_req_if.sv]
// ---------------------------------------------------------------------------
// dqci_req_if
// Request channel: valid/ready handshake carrying one operation word.
// ---------------------------------------------------------------------------
interface dqci_req_if;
   logic               valid;
   logic               ready;
   dqci_pkg::mode_type mode;
   dqci_pkg::data_type value;
   dqci_pkg::pos_type  position;

   modport source (output valid, output mode, output value, output position, input ready);
   modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

[design/dqci_rsp_if.sv]
// ---------------------------------------------------------------------------
// dqci_rsp_if
// Response channel: valid/ready handshake carrying one result word.
// ---------------------------------------------------------------------------
interface dqci_rsp_if;
   logic                 valid;
   logic                 ready;
   dqci_pkg::data_type   data;
   dqci_pkg::count_type  count;
   dqci_pkg::status_type status;

   modport source (output valid, output data, output count, output status, input ready);
   modport sink   (input valid, input data, input count, input status, output ready);
endinterface

[design/deque_with_clamped_index.sv]
// ---------------------------------------------------------------------------
// deque_with_clamped_index
// Bounded double-ended queue of signed 32-bit entries in a ring memory.
// ---------------------------------------------------------------------------
// One request word is taken at a time. Pushes, index writes, rejected
// operations and unused codes are done in the cycle the request is taken:
// the entry, if any, is written and the response word is loaded. Pops and
// index reads pass the entry through the memory read register and then
// into the response register. The response register lets a new request be
// taken in the same cycle that the previous response is drained. An index
// below zero selects the front entry, and one at or past the count selects
// the last.
module deque_with_clamped_index (
   input logic         clock,
   input logic         reset,
   dqci_req_if.sink    req_chan,
   dqci_rsp_if.source  rsp_chan
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // Ring storage, read data registered
   dqci_pkg::data_type mem [dqci_pkg::DEPTH];
   dqci_pkg::data_type rd_data_ff;

   state_type            state_ff, state_in;
   dqci_pkg::slot_type   front_ff, front_in;
   dqci_pkg::count_type  count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dqci_pkg::data_type   rsp_data_ff;
   dqci_pkg::count_type  rsp_count_ff;
   dqci_pkg::status_type rsp_status_ff;

   logic                 req_accept;
   logic                 is_full;
   logic                 is_empty;
   dqci_pkg::slot_type   last_off;
   dqci_pkg::slot_type   idx_off;
   dqci_pkg::slot_type   wr_addr;
   dqci_pkg::slot_type   rd_addr;
   logic                 wr_en;
   logic                 rd_en;
   dqci_pkg::status_type status_in;

   // Take a request when idle and the response register is free or draining
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign is_full  = (count_ff == dqci_pkg::CNT_W'(dqci_pkg::DEPTH));
   assign is_empty = (count_ff == '0);
   assign last_off = dqci_pkg::SLOT_W'(count_ff - 1'b1);

   // Clamp the signed position onto the held entries
   always_comb begin
      if (req_chan.position[dqci_pkg::POS_W-1]) begin
         idx_off = '0;
      end else if (req_chan.position >= dqci_pkg::POS_W'(count_ff)) begin
         idx_off = last_off;
      end else begin
         idx_off = req_chan.position[dqci_pkg::SLOT_W-1:0];
      end
   end

   // Decode the operation into memory accesses and pointer updates
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = dqci_pkg::slot_add(front_ff, dqci_pkg::SLOT_W'(count_ff));
      rd_addr   = front_ff;
      status_in = dqci_pkg::STAT_OK;
      case (req_chan.mode) inside
         dqci_pkg::MODE_PUSH_FRONT, dqci_pkg::MODE_PUSH_BACK: begin
            if (is_full) begin
               status_in = dqci_pkg::STAT_FULL;
            end else begin
               wr_en    = req_accept;
               count_in = count_ff + 1'b1;
               if (req_chan.mode == dqci_pkg::MODE_PUSH_FRONT) begin
                  front_in = dqci_pkg::slot_dec(front_ff);
                  wr_addr  = dqci_pkg::slot_dec(front_ff);
               end
            end
         end
         dqci_pkg::MODE_POP_FRONT, dqci_pkg::MODE_POP_BACK,
         dqci_pkg::MODE_READ_IDX, dqci_pkg::MODE_WRITE_IDX: begin
            if (is_empty) begin
               status_in = dqci_pkg::STAT_EMPTY;
            end else if (req_chan.mode == dqci_pkg::MODE_POP_FRONT) begin
               rd_en    = req_accept;
               front_in = dqci_pkg::slot_add(front_ff, dqci_pkg::SLOT_W'(1));
               count_in = count_ff - 1'b1;
            end else if (req_chan.mode == dqci_pkg::MODE_POP_BACK) begin
               rd_en    = req_accept;
               rd_addr  = dqci_pkg::slot_add(front_ff, last_off);
               count_in = count_ff - 1'b1;
            end else if (req_chan.mode == dqci_pkg::MODE_READ_IDX) begin
               rd_en   = req_accept;
               rd_addr = dqci_pkg::slot_add(front_ff, idx_off);
            end else begin
               wr_en   = req_accept;
               wr_addr = dqci_pkg::slot_add(front_ff, idx_off);
            end
         end
         default: begin
         end
      endcase
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_chan.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Next state: wait in ST_READ for memory data on pops and reads
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (rd_en) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold a waiting response, load one on a finished request or memory data
   assign rsp_valid_in = (rsp_valid_ff && !rsp_chan.ready) || (req_accept && !rd_en) ||
                         (state_ff == ST_READ);

   // Hold state, pointers and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            front_ff      <= front_in;
            count_ff      <= count_in;
            rsp_count_ff  <= count_in;
            rsp_status_ff <= status_in;
            rsp_data_ff   <= '0;
         end
         if (state_ff == ST_READ) begin
            rsp_data_ff <= rd_data_ff;
         end
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign rsp_chan.count  = rsp_count_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule

[dv/dqci_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dqci_checker
// Watches both channels of the clamped-index deque, keeps its own ring of
// entries, predicts each response word and compares it field by field.
// ---------------------------------------------------------------------------
module dqci_checker
   import dqci_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  mode_type   req_mode,
   input  data_type   req_value,
   input  pos_type    req_position,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  data_type   rsp_data,
   input  count_type  rsp_count,
   input  status_type rsp_status,
   output int         mismatch_count,
   output int         awaiting_count
);

   typedef struct packed {
      data_type   data;
      count_type  count;
      status_type status;
   } outcome_t;

   // Shadow deque: ring of entries, front slot and number held
   data_type  shadow_ring [DEPTH];
   int        shadow_front;
   int        shadow_held;

   // Outcomes predicted for accepted words, oldest first
   outcome_t  predicted_outcomes [$];

   initial begin
      mismatch_count = 0;
      awaiting_count = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // Map an offset from the front to a ring slot
   function automatic int ring_slot(input int offset);
      return (shadow_front + offset) % DEPTH;
   endfunction

   // Apply one operation to the shadow deque and return the response it causes
   function automatic outcome_t apply_deque_op(input mode_type op, input data_type word,
                                               input pos_type idx);
      outcome_t res;
      int       target;
      res.data   = '0;
      res.status = STAT_OK;
      case (op)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (shadow_held >= DEPTH) begin
               res.status = STAT_FULL;
            end else if (op == MODE_PUSH_FRONT) begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_ring[shadow_front] = word;
               shadow_held++;
            end else begin
               shadow_ring[ring_slot(shadow_held)] = word;
               shadow_held++;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK, MODE_READ_IDX, MODE_WRITE_IDX: begin
            if (shadow_held == 0) begin
               res.status = STAT_EMPTY;
            end else if (op == MODE_POP_FRONT) begin
               res.data = shadow_ring[ring_slot(0)];
               shadow_front = ring_slot(1);
               shadow_held--;
            end else if (op == MODE_POP_BACK) begin
               res.data = shadow_ring[ring_slot(shadow_held - 1)];
               shadow_held--;
            end else begin
               // clamp the index into the held range
               if (idx < 0) begin
                  target = 0;
               end else if (int'(idx) >= shadow_held) begin
                  target = shadow_held - 1;
               end else begin
                  target = int'(idx);
               end
               if (op == MODE_READ_IDX) begin
                  res.data = shadow_ring[ring_slot(target)];
               end else begin
                  shadow_ring[ring_slot(target)] = word;
               end
            end
         end
         default: begin
            // unused codes leave the deque untouched
         end
      endcase
      res.count = count_type'(shadow_held);
      return res;
   endfunction

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         shadow_front = 0;
         shadow_held  = 0;
         foreach (shadow_ring[i]) shadow_ring[i] = '0;
         predicted_outcomes.delete();
      end else begin
         if (req_valid && req_ready) begin
            predicted_outcomes.push_back(apply_deque_op(req_mode, req_value, req_position));
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_outcomes.size() == 0) begin
               report_mismatch("response word with nothing pending",
                               32'(rsp_data), 32'(0));
            end else begin
               want = predicted_outcomes.pop_front();
               if (rsp_data !== want.data) begin
                  report_mismatch("data", 32'(rsp_data), 32'(want.data));
               end
               if (rsp_count !== want.count) begin
                  report_mismatch("count", 32'(rsp_count), 32'(want.count));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               end
            end
         end
      end
      awaiting_count <= predicted_outcomes.size();
   end

endmodule

[dv/tb_deque_with_clamped_index.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_deque_with_clamped_index
// Drives operation words into the clamped-index deque with bursty timing and
// a stalling receiver; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb_deque_with_clamped_index;
   import dqci_pkg::*;

   localparam int RANDOM_WORDS   = 1850;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   // Codes past the last operation; the block treats them as no-ops
   localparam mode_type MODE_UNUSED_A = 3'd6;
   localparam mode_type MODE_UNUSED_B = 3'd7;

   typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_e;
   typedef enum int {DRAIN_FREE, DRAIN_LIGHT, DRAIN_PERIODIC, DRAIN_HEAVY} drain_e;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   int     mismatch_count;
   int     awaiting_count;
   int     burst_left = 0;
   int     idle_cycles = 0;
   int     stall_tick = 0;
   drain_e drain_style = DRAIN_FREE;

   dqci_req_if req_bus ();
   dqci_rsp_if rsp_bus ();

   always #6 clock = ~clock;

   deque_with_clamped_index uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   dqci_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_mode       (req_bus.mode),
      .req_value      (req_bus.value),
      .req_position   (req_bus.position),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_data       (rsp_bus.data),
      .rsp_count      (rsp_bus.count),
      .rsp_status     (rsp_bus.status),
      .mismatch_count (mismatch_count),
      .awaiting_count (awaiting_count)
   );

   // Receiver: switch stall style every so often
   always @(posedge clock) begin
      stall_tick = stall_tick + 1;
      if (stall_tick % 150 == 0) begin
         drain_style = drain_e'($urandom_range(0, 3));
      end
      case (drain_style)
         DRAIN_FREE:     rsp_bus.ready <= 1'b1;
         DRAIN_LIGHT:    rsp_bus.ready <= ($urandom_range(0, 99) < 70);
         DRAIN_PERIODIC: rsp_bus.ready <= (stall_tick % 3 == 0);
         default:        rsp_bus.ready <= ($urandom_range(0, 99) < 25);
      endcase
   end

   // Watchdog: end the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("deque_with_clamped_index: mismatch");
            $finish;
         end
      end
   end

   // Offer one word, idling between bursts, and hold it until taken
   task automatic send_word(input mode_type op, input data_type word, input pos_type idx);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= op;
      req_bus.value    <= word;
      req_bus.position <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   function automatic mode_type pick_mode(input lean_e lean);
      int r;
      r = $urandom_range(0, 99);
      case (lean)
         LEAN_FILL: begin
            if (r < 35)      return MODE_PUSH_FRONT;
            else if (r < 70) return MODE_PUSH_BACK;
            else if (r < 78) return MODE_POP_FRONT;
            else if (r < 86) return MODE_POP_BACK;
            else if (r < 93) return MODE_READ_IDX;
            else             return MODE_WRITE_IDX;
         end
         LEAN_DRAIN: begin
            if (r < 10)      return MODE_PUSH_FRONT;
            else if (r < 20) return MODE_PUSH_BACK;
            else if (r < 45) return MODE_POP_FRONT;
            else if (r < 70) return MODE_POP_BACK;
            else if (r < 85) return MODE_READ_IDX;
            else             return MODE_WRITE_IDX;
         end
         default: begin
            case ($urandom_range(0, 5))
               0:       return MODE_PUSH_FRONT;
               1:       return MODE_PUSH_BACK;
               2:       return MODE_POP_FRONT;
               3:       return MODE_POP_BACK;
               4:       return MODE_READ_IDX;
               default: return MODE_WRITE_IDX;
            endcase
         end
      endcase
   endfunction

   // Mostly in-range indexes, with negatives, overshoots and the extremes
   function automatic pos_type pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)      return pos_type'($urandom_range(0, DEPTH + 1));
      else if (r < 75) return -pos_type'($urandom_range(1, 40));
      else if (r < 85) return pos_type'($urandom_range(DEPTH, 32767));
      else if (r < 90) return pos_type'(16'h8000);
      else if (r < 95) return pos_type'(16'h7fff);
      else             return pos_type'($urandom);
   endfunction

   function automatic data_type pick_value();
      case ($urandom_range(0, 19))
         0:       return data_type'(32'h8000_0000);
         1:       return data_type'(32'h7fff_ffff);
         2:       return '0;
         3:       return '1;
         default: return data_type'($urandom);
      endcase
   endfunction

   initial begin
      lean_e lean;
      req_bus.valid    = 1'b0;
      req_bus.mode     = MODE_PUSH_BACK;
      req_bus.value    = '0;
      req_bus.position = '0;
      rsp_bus.ready    = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Operations on the empty deque, and an unused code
      send_word(MODE_POP_FRONT, 32'sd5, 16'sd0);
      send_word(MODE_POP_BACK, 32'sd6, 16'sd0);
      send_word(MODE_READ_IDX, 32'sd7, 16'sd0);
      send_word(MODE_WRITE_IDX, 32'sd8, 16'sd3);
      send_word(MODE_UNUSED_A, 32'sd9, 16'sd1);

      // Fill to the brim from both ends with extreme words
      for (int i = 0; i < DEPTH; i++) begin
         send_word((i % 2 == 0) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
                   (i % 4 < 2) ? data_type'(32'h8000_0000 + i) : data_type'(32'h7fff_ffff - i),
                   16'sd0);
      end

      // Pushes against a full deque
      send_word(MODE_PUSH_BACK, -32'sd1, 16'sd0);
      send_word(MODE_PUSH_FRONT, 32'sd0, 16'sd0);

      // Clamped indexes at both extremes and exactly at the count
      send_word(MODE_READ_IDX, 32'sd0, pos_type'(16'h8000));
      send_word(MODE_READ_IDX, 32'sd0, pos_type'(16'h7fff));
      send_word(MODE_WRITE_IDX, 32'sh5a5a_a5a5, pos_type'(DEPTH));
      send_word(MODE_UNUSED_B, 32'sd1, 16'sd2);

      // Random words, leaning toward filling or draining in stretches
      lean = LEAN_EVEN;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 40 == 0) begin
            lean = lean_e'($urandom_range(0, 2));
         end
         send_word(pick_mode(lean), pick_value(), pick_position());
      end

      // Let every response drain, then settle
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaiting_count == 0) begin
         $display("deque_with_clamped_index: match");
      end else begin
         $display("deque_with_clamped_index: mismatch");
      end
      $finish;
   end

endmodule
